// ----- rtl/lltm_pkg.sv -----
// Shared sizes, types and codes of the lane line track matcher.
// Used by every module of the block; depends on nothing.
package lltm_pkg;

    localparam int SLOTS      = 32;
    localparam int LINES      = 2;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LIDX_W     = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int LOAD_W     = $clog2(LINES + 1);
    localparam int USES_W     = $clog2(LINES + 1);
    localparam int RHO_W      = 16;
    localparam int THETA_W    = 15;
    localparam int CNT_W      = 6;
    localparam int THR_W      = 16;
    localparam int DIST_W     = 22;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_CEILING   = 2'd1;

    localparam logic [1:0] OUT_MATCHED  = 2'd0;
    localparam logic [1:0] OUT_INSERTED = 2'd1;
    localparam logic [1:0] OUT_DROPPED  = 2'd2;
    localparam logic [1:0] OUT_DISABLED = 2'd3;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [CNT_W-1:0]  data;
    } cnt_wr_t;

    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  addr;
        logic [RHO_W-1:0]   rho;
        logic [THETA_W-1:0] theta;
    } line_wr_t;

    typedef struct packed {
        logic [CNT_W-1:0]   cnt;
        logic [RHO_W-1:0]   rho;
        logic [THETA_W-1:0] theta;
    } slot_rd_t;

endpackage

// ----- rtl/lane_line_track_matcher.sv -----
// Lane line track matcher: top level with frame buffer, greedy pairing control and output.
// Depends on lltm_pkg, lltm_slot_mem and lltm_dist_stage.
//
// A line request that is not last gives no result. The last line of a frame starts
// matching: with n buffered lines there are up to n+1 scan rounds over the slot memory,
// each followed by a pick step, then an append pass over all LINES buffer entries that
// appends unpaired lines, an update pass over the ordered lines, and a count sweep over
// all slots. The scans read one slot at a time through the single read port of the slot
// memory. Then n results follow, one a cycle while the consumer takes them. Input is not
// taken again until the last result is loaded.
module lane_line_track_matcher (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lltm_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [lltm_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [15:0]                s_line_rho,
    input  logic signed [14:0]                s_line_theta,
    input  logic                              s_line_enable,
    input  logic                              s_last_line,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_line_index,
    output logic [5:0]                        m_slot_index,
    output logic [1:0]                        m_outcome,
    output logic [5:0]                        m_slot_count,
    output logic                              m_last_result
);
    import lltm_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCAN   = 7'b0000010,
        ST_PICK   = 7'b0000100,
        ST_APPEND = 7'b0001000,
        ST_APPLY  = 7'b0010000,
        ST_SWEEP  = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [THR_W-1:0]  thr_reg, thr_next;
    logic [CNT_W-1:0]  ceil_reg, ceil_next;
    logic [LOAD_W-1:0] loaded_reg, loaded_next;
    logic [SLOT_W:0]   addr_reg, addr_next;
    logic [LOAD_W-1:0] k_reg, k_next;
    logic [LOAD_W-1:0] norder_reg, norder_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;

    logic [LINES-1:0][RHO_W-1:0]   buf_rho_reg, buf_rho_next;
    logic [LINES-1:0][THETA_W-1:0] buf_theta_reg, buf_theta_next;
    logic [LINES-1:0]              buf_en_reg, buf_en_next;

    logic [LINES-1:0]              done_reg, done_next;
    logic [LINES-1:0]              found_reg, found_next;
    logic [LINES-1:0][DIST_W-1:0]  best_d_reg, best_d_next;
    logic [LINES-1:0][SLOT_W-1:0]  best_s_reg, best_s_next;
    logic [LINES-1:0][1:0]         res_out_reg, res_out_next;
    logic [LINES-1:0][SLOT_W-1:0]  res_slot_reg, res_slot_next;
    logic [LINES-1:0][CNT_W-1:0]   res_cnt_reg, res_cnt_next;
    logic [LINES-1:0][LIDX_W-1:0]  order_reg, order_next;

    logic [SLOTS-1:0]              taken_reg, taken_next;
    logic [SLOTS-1:0]              low_reg, low_next;
    logic [SLOTS-1:0]              used_reg, used_next;
    logic [SLOTS-1:0][USES_W-1:0]  uses_reg, uses_next;

    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_line_index_reg, m_line_index_next;
    logic [5:0]        m_slot_index_reg, m_slot_index_next;
    logic [1:0]        m_outcome_reg, m_outcome_next;
    logic [5:0]        m_slot_count_reg, m_slot_count_next;
    logic              m_last_result_reg, m_last_result_next;

    rd_req_t                     rd_req;
    cnt_wr_t                     cnt_wr;
    line_wr_t                    line_wr;
    slot_rd_t                    rd_data;
    logic                        d_vld;
    logic [SLOT_W-1:0]           d_slot;
    logic [CNT_W-1:0]            d_cnt;
    logic [LINES-1:0][DIST_W-1:0] d_dist;

    logic [DIST_W-1:0] thr32;
    logic              pick_found;
    logic [LIDX_W-1:0] pick_j;
    logic [DIST_W-1:0] pick_d;
    logic [SLOT_W-1:0] pick_s;
    logic              free_found;
    logic [SLOT_W-1:0] free_s;
    logic [CNT_W+USES_W+1:0] sum_cnt;
    logic [CNT_W+USES_W+1:0] dec_cnt;
    logic [CNT_W-1:0]  new_cnt;
    logic              out_load;

    lltm_slot_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_req  (rd_req),
        .cnt_wr  (cnt_wr),
        .line_wr (line_wr),
        .rd_data (rd_data)
    );

    lltm_dist_stage u_dist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_vld     (rd_vld_reg && (state_reg == ST_SCAN)),
        .in_slot    (rd_slot_reg),
        .in_data    (rd_data),
        .line_rho   (buf_rho_reg),
        .line_theta (buf_theta_reg),
        .out_vld    (d_vld),
        .out_slot   (d_slot),
        .out_cnt    (d_cnt),
        .out_dist   (d_dist)
    );

    assign thr32 = DIST_W'({thr_reg, 5'b0});

    // Smallest found distance over the lines; ties go to the lowest line.
    always_comb begin
        pick_found = 1'b0;
        pick_j     = '0;
        pick_d     = '0;
        pick_s     = '0;
        for (int j = 0; j < LINES; j++) begin
            if (found_reg[j] && (!pick_found || best_d_reg[j] < pick_d)) begin
                pick_found = 1'b1;
                pick_j     = LIDX_W'(j);
                pick_d     = best_d_reg[j];
                pick_s     = best_s_reg[j];
            end
        end
    end

    // A slot is free for an insertion while its decremented count is still zero or less.
    always_comb begin
        free_found = 1'b0;
        free_s     = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (low_reg[s] && !used_reg[s]) begin
                free_found = 1'b1;
                free_s     = SLOT_W'(s);
            end
        end
    end

    always_comb begin
        sum_cnt = (CNT_W+USES_W+2)'(rd_data.cnt)
                + (CNT_W+USES_W+2)'({uses_reg[rd_slot_reg], 1'b0});
        dec_cnt = sum_cnt - (CNT_W+USES_W+2)'(1);
        if (sum_cnt == '0) begin
            new_cnt = '0;
        end else if (dec_cnt > (CNT_W+USES_W+2)'(ceil_reg)) begin
            new_cnt = ceil_reg;
        end else begin
            new_cnt = dec_cnt[CNT_W-1:0];
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (k_reg < loaded_reg)
                   && (!m_valid_reg || m_ready);

    always_comb begin
        logic [LIDX_W-1:0] l;
        logic [LIDX_W-1:0] kl;
        logic [LOAD_W-1:0] n_new;
        state_next     = state_reg;
        thr_next       = thr_reg;
        ceil_next      = ceil_reg;
        loaded_next    = loaded_reg;
        addr_next      = addr_reg;
        k_next         = k_reg;
        norder_next    = norder_reg;
        rd_vld_next    = 1'b0;
        rd_slot_next   = addr_reg[SLOT_W-1:0];
        buf_rho_next   = buf_rho_reg;
        buf_theta_next = buf_theta_reg;
        buf_en_next    = buf_en_reg;
        done_next      = done_reg;
        found_next     = found_reg;
        best_d_next    = best_d_reg;
        best_s_next    = best_s_reg;
        res_out_next   = res_out_reg;
        res_slot_next  = res_slot_reg;
        res_cnt_next   = res_cnt_reg;
        order_next     = order_reg;
        taken_next     = taken_reg;
        low_next       = low_reg;
        used_next      = used_reg;
        uses_next      = uses_reg;
        m_valid_next       = m_valid_reg;
        m_line_index_next  = m_line_index_reg;
        m_slot_index_next  = m_slot_index_reg;
        m_outcome_next     = m_outcome_reg;
        m_slot_count_next  = m_slot_count_reg;
        m_last_result_next = m_last_result_reg;
        rd_req   = '0;
        cnt_wr   = '0;
        line_wr  = '0;
        l        = order_reg[k_reg[LIDX_W-1:0]];
        kl       = k_reg[LIDX_W-1:0];
        n_new    = loaded_reg;

        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_MATCH_THRESHOLD: thr_next  = cfg_wr_data[THR_W-1:0];
                REG_COUNT_CEILING:   ceil_next = cfg_wr_data[CNT_W-1:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if ((state_reg == ST_SCAN || state_reg == ST_SWEEP)
                && addr_reg < (SLOT_W+1)'(SLOTS)) begin
            rd_req.en   = 1'b1;
            rd_req.addr = addr_reg[SLOT_W-1:0];
            rd_vld_next = 1'b1;
            addr_next   = addr_reg + (SLOT_W+1)'(1);
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (loaded_reg < LOAD_W'(LINES)) begin
                        buf_rho_next[loaded_reg[LIDX_W-1:0]]   = s_line_rho;
                        buf_theta_next[loaded_reg[LIDX_W-1:0]] = s_line_theta;
                        buf_en_next[loaded_reg[LIDX_W-1:0]]    = s_line_enable;
                        n_new = loaded_reg + LOAD_W'(1);
                    end
                    loaded_next = n_new;
                    if (s_last_line) begin
                        for (int j = 0; j < LINES; j++) begin
                            done_next[j]     = (LOAD_W'(j) >= n_new) || !buf_en_next[j];
                            res_out_next[j]  = OUT_DISABLED;
                            res_slot_next[j] = '0;
                            res_cnt_next[j]  = '0;
                        end
                        found_next  = '0;
                        norder_next = '0;
                        taken_next  = '0;
                        used_next   = '0;
                        uses_next   = '0;
                        addr_next   = '0;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (d_vld) begin
                    low_next[d_slot] = (d_cnt <= CNT_W'(1));
                    if (d_cnt != '0 && !taken_reg[d_slot]) begin
                        for (int j = 0; j < LINES; j++) begin
                            if (!done_reg[j]
                                    && (!found_reg[j] || d_dist[j] < best_d_reg[j])) begin
                                found_next[j]  = 1'b1;
                                best_d_next[j] = d_dist[j];
                                best_s_next[j] = d_slot;
                            end
                        end
                    end
                end
                if (addr_reg == (SLOT_W+1)'(SLOTS) && !rd_vld_reg && !d_vld) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                if (pick_found) begin
                    done_next[pick_j]  = 1'b1;
                    taken_next[pick_s] = 1'b1;
                    if (pick_d <= thr32) begin
                        res_out_next[pick_j]  = OUT_MATCHED;
                        res_slot_next[pick_j] = pick_s;
                    end else begin
                        res_out_next[pick_j] = OUT_INSERTED;
                    end
                    order_next[norder_reg[LIDX_W-1:0]] = pick_j;
                    norder_next = norder_reg + LOAD_W'(1);
                    found_next  = '0;
                    addr_next   = '0;
                    state_next  = ST_SCAN;
                end else begin
                    k_next     = '0;
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND: begin
                // Enabled lines left unpaired become insertions in line order.
                if (k_reg < loaded_reg && !done_reg[kl]) begin
                    res_out_next[kl] = OUT_INSERTED;
                    order_next[norder_reg[LIDX_W-1:0]] = kl;
                    norder_next = norder_reg + LOAD_W'(1);
                end
                if (k_reg == LOAD_W'(LINES - 1)) begin
                    k_next     = '0;
                    state_next = ST_APPLY;
                end else begin
                    k_next = k_reg + LOAD_W'(1);
                end
            end
            ST_APPLY: begin
                if (k_reg < norder_reg) begin
                    k_next = k_reg + LOAD_W'(1);
                    if (res_out_reg[l] == OUT_MATCHED) begin
                        line_wr.en   = 1'b1;
                        line_wr.addr = res_slot_reg[l];
                    end else if (free_found) begin
                        line_wr.en       = 1'b1;
                        line_wr.addr     = free_s;
                        res_slot_next[l] = free_s;
                    end else begin
                        res_out_next[l]  = OUT_DROPPED;
                        res_slot_next[l] = '0;
                    end
                    line_wr.rho   = buf_rho_reg[l];
                    line_wr.theta = buf_theta_reg[l];
                    if (line_wr.en) begin
                        used_next[line_wr.addr] = 1'b1;
                        uses_next[line_wr.addr] = uses_reg[line_wr.addr] + USES_W'(1);
                    end
                end else begin
                    addr_next  = '0;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (rd_vld_reg) begin
                    cnt_wr.en   = 1'b1;
                    cnt_wr.addr = rd_slot_reg;
                    cnt_wr.data = new_cnt;
                    for (int j = 0; j < LINES; j++) begin
                        if (res_slot_reg[j] == rd_slot_reg
                                && (res_out_reg[j] == OUT_MATCHED
                                    || res_out_reg[j] == OUT_INSERTED)) begin
                            res_cnt_next[j] = new_cnt;
                        end
                    end
                end
                if (addr_reg == (SLOT_W+1)'(SLOTS) && !rd_vld_reg) begin
                    k_next     = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    m_valid_next       = 1'b1;
                    m_line_index_next  = 3'(k_reg);
                    m_slot_index_next  = 6'(res_slot_reg[kl]);
                    m_outcome_next     = res_out_reg[kl];
                    m_slot_count_next  = res_cnt_reg[kl];
                    m_last_result_next = (k_reg + LOAD_W'(1) == loaded_reg);
                    k_next             = k_reg + LOAD_W'(1);
                    if (k_reg + LOAD_W'(1) == loaded_reg) begin
                        loaded_next = '0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            thr_reg     <= THR_W'(1200);
            ceil_reg    <= CNT_W'(25);
            loaded_reg  <= '0;
            addr_reg    <= '0;
            k_reg       <= '0;
            norder_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            done_reg    <= '0;
            found_reg   <= '0;
            taken_reg   <= '0;
            used_reg    <= '0;
            uses_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            thr_reg     <= thr_next;
            ceil_reg    <= ceil_next;
            loaded_reg  <= loaded_next;
            addr_reg    <= addr_next;
            k_reg       <= k_next;
            norder_reg  <= norder_next;
            rd_vld_reg  <= rd_vld_next;
            done_reg    <= done_next;
            found_reg   <= found_next;
            taken_reg   <= taken_next;
            used_reg    <= used_next;
            uses_reg    <= uses_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_slot_reg       <= rd_slot_next;
        buf_rho_reg       <= buf_rho_next;
        buf_theta_reg     <= buf_theta_next;
        buf_en_reg        <= buf_en_next;
        best_d_reg        <= best_d_next;
        best_s_reg        <= best_s_next;
        res_out_reg       <= res_out_next;
        res_slot_reg      <= res_slot_next;
        res_cnt_reg       <= res_cnt_next;
        order_reg         <= order_next;
        low_reg           <= low_next;
        m_line_index_reg  <= m_line_index_next;
        m_slot_index_reg  <= m_slot_index_next;
        m_outcome_reg     <= m_outcome_next;
        m_slot_count_reg  <= m_slot_count_next;
        m_last_result_reg <= m_last_result_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_line_index  = m_line_index_reg;
    assign m_slot_index  = m_slot_index_reg;
    assign m_outcome     = m_outcome_reg;
    assign m_slot_count  = m_slot_count_reg;
    assign m_last_result = m_last_result_reg;

    a_onehot_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state register is not one-hot");

    a_no_count_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !cnt_wr.en)
        else $error("count memory written during a scan round");

    a_unused_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_outcome == OUT_DROPPED || m_outcome == OUT_DISABLED))
            |-> (m_slot_index == '0 && m_slot_count == '0))
        else $error("dropped or disabled result carries a slot");

    a_line_write_only_in_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        line_wr.en |-> (state_reg == ST_APPLY))
        else $error("line memory written outside the update phase");

endmodule

// ----- rtl/lltm_slot_mem.sv -----
// Slot store: confidence count memory and line parameter memory, one read port.
// Depends on lltm_pkg; counts of never-written slots read as zero.
module lltm_slot_mem (
    input  logic               aclk,
    input  logic               aresetn,
    input  lltm_pkg::rd_req_t  rd_req,
    input  lltm_pkg::cnt_wr_t  cnt_wr,
    input  lltm_pkg::line_wr_t line_wr,
    output lltm_pkg::slot_rd_t rd_data
);
    import lltm_pkg::*;

    logic [CNT_W-1:0]   cnt_mem   [SLOTS];
    logic [RHO_W-1:0]   rho_mem   [SLOTS];
    logic [THETA_W-1:0] theta_mem [SLOTS];
    logic [SLOTS-1:0]   cnt_valid_reg;
    logic [CNT_W-1:0]   cnt_q_reg;
    logic               vld_q_reg;
    logic [RHO_W-1:0]   rho_q_reg;
    logic [THETA_W-1:0] theta_q_reg;

    always_ff @(posedge aclk) begin
        if (cnt_wr.en) begin
            cnt_mem[cnt_wr.addr] <= cnt_wr.data;
        end
        if (line_wr.en) begin
            rho_mem[line_wr.addr]   <= line_wr.rho;
            theta_mem[line_wr.addr] <= line_wr.theta;
        end
        if (rd_req.en) begin
            cnt_q_reg   <= cnt_mem[rd_req.addr];
            vld_q_reg   <= cnt_valid_reg[rd_req.addr];
            rho_q_reg   <= rho_mem[rd_req.addr];
            theta_q_reg <= theta_mem[rd_req.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_valid_reg <= '0;
        end else if (cnt_wr.en) begin
            cnt_valid_reg[cnt_wr.addr] <= 1'b1;
        end
    end

    assign rd_data.cnt   = vld_q_reg ? cnt_q_reg : '0;
    assign rd_data.rho   = rho_q_reg;
    assign rd_data.theta = theta_q_reg;

endmodule

// ----- rtl/lltm_dist_stage.sv -----
// Registered distance stage: 32*|drho| + 25*|dtheta| between one slot and every line.
// Depends on lltm_pkg.
module lltm_dist_stage (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        in_vld,
    input  logic [lltm_pkg::SLOT_W-1:0]                 in_slot,
    input  lltm_pkg::slot_rd_t                          in_data,
    input  logic [lltm_pkg::LINES-1:0][lltm_pkg::RHO_W-1:0]   line_rho,
    input  logic [lltm_pkg::LINES-1:0][lltm_pkg::THETA_W-1:0] line_theta,
    output logic                                        out_vld,
    output logic [lltm_pkg::SLOT_W-1:0]                 out_slot,
    output logic [lltm_pkg::CNT_W-1:0]                  out_cnt,
    output logic [lltm_pkg::LINES-1:0][lltm_pkg::DIST_W-1:0]  out_dist
);
    import lltm_pkg::*;

    logic [LINES-1:0][DIST_W-1:0] line_dist;
    logic                         vld_reg;
    logic [SLOT_W-1:0]            slot_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [LINES-1:0][DIST_W-1:0] dist_reg;

    always_comb begin
        for (int j = 0; j < LINES; j++) begin
            logic signed [RHO_W:0]   drho;
            logic signed [THETA_W:0] dth;
            logic [RHO_W:0]          arho;
            logic [THETA_W:0]        ath;
            drho = $signed({line_rho[j][RHO_W-1], line_rho[j]})
                 - $signed({in_data.rho[RHO_W-1], in_data.rho});
            dth  = $signed({line_theta[j][THETA_W-1], line_theta[j]})
                 - $signed({in_data.theta[THETA_W-1], in_data.theta});
            arho = drho[RHO_W] ? (RHO_W+1)'(-drho) : (RHO_W+1)'(drho);
            ath  = dth[THETA_W] ? (THETA_W+1)'(-dth) : (THETA_W+1)'(dth);
            line_dist[j] = DIST_W'({arho[RHO_W-1:0], 5'b0})
                         + DIST_W'({ath[THETA_W-1:0], 4'b0})
                         + DIST_W'({ath[THETA_W-1:0], 3'b0})
                         + DIST_W'(ath[THETA_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= in_slot;
        cnt_reg  <= in_data.cnt;
        dist_reg <= line_dist;
    end

    assign out_vld  = vld_reg;
    assign out_slot = slot_reg;
    assign out_cnt  = cnt_reg;
    assign out_dist = dist_reg;

endmodule

// ----- sim/tb_lane_line_track_matcher.sv -----
// Self-checking testbench of the lane line track matcher: directed frames, then random frames.
// Depends on lltm_pkg and lane_line_track_matcher; a local track model predicts every result.
module tb_lane_line_track_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    import lltm_pkg::*;

    localparam int LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE = 250;
    localparam int N_DIR = 16;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [2:0] line_idx;
        logic [5:0] slot;
        logic [1:0] outcome;
        logic [5:0] count;
        logic       last;
    } track_res_t;

    typedef struct {
        logic signed [15:0] rho;
        logic signed [14:0] theta;
        bit                 en;
        bit                 last;
        int                 n_typed;
        track_res_t         typed[2];
    } line_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_line_rho = '0;
    logic signed [14:0] s_line_theta = '0;
    logic s_line_enable = 1'b0;
    logic s_last_line = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [2:0] m_line_index;
    logic [5:0] m_slot_index;
    logic [1:0] m_outcome;
    logic [5:0] m_slot_count;
    logic m_last_result;

    lane_line_track_matcher i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_line_rho(s_line_rho), .s_line_theta(s_line_theta),
        .s_line_enable(s_line_enable), .s_last_line(s_last_line),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_line_index(m_line_index), .m_slot_index(m_slot_index), .m_outcome(m_outcome),
        .m_slot_count(m_slot_count), .m_last_result(m_last_result)
    );

    // Track model state
    int track_conf[SLOTS];
    int track_rho[SLOTS];
    int track_theta[SLOTS];
    int frame_rho[LINES];
    int frame_theta[LINES];
    bit frame_en[LINES];
    int frame_loaded;
    int match_thr;
    int conf_ceiling;

    track_res_t pending_res[$];
    int errors = 0;
    int cycles = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int ready_pct = 100;
    int burst_left = 0;
    line_row_t dir_tab[N_DIR];

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stall pattern, plus a long hold-off on request from the stimulus.
    always @(posedge aclk) begin
        if (cycles % 64 == 0) begin
            case ($urandom_range(0, 2))
                0: ready_pct = 100;
                1: ready_pct = 70;
                default: ready_pct = 25;
            endcase
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    always @(posedge aclk) begin
        track_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_res.size() == 0) begin
                errors++;
                $display("%0t: unexpected result line %0d slot %0d outcome %0d count %0d",
                         $time, m_line_index, m_slot_index, m_outcome, m_slot_count);
            end else begin
                want = pending_res.pop_front();
                if (want !== {m_line_index, m_slot_index, m_outcome, m_slot_count,
                              m_last_result}) begin
                    errors++;
                    $display("%0t: mismatch expected line %0d slot %0d outcome %0d count %0d last %0b",
                             $time, want.line_idx, want.slot, want.outcome, want.count, want.last);
                    $display("%0t:          actual   line %0d slot %0d outcome %0d count %0d last %0b",
                             $time, m_line_index, m_slot_index, m_outcome, m_slot_count,
                             m_last_result);
                end
            end
        end
    end

    function automatic longint abs_diff(input int a, input int b);
        return (a > b) ? longint'(a) - b : longint'(b) - a;
    endfunction

    // Buffers one line; on the frame's last line runs the greedy association.
    task automatic track_line(input int rho, input int theta, input bit en, input bit last);
        int cnt[SLOTS];
        bit live[SLOTS];
        bit taken[SLOTS];
        bit done[LINES];
        int order[LINES];
        int rslot[LINES];
        logic [1:0] rout[LINES];
        int n, nord, j, s, bj, bs, c;
        longint d, best;
        bit found;
        track_res_t r;
        if (frame_loaded < LINES) begin
            frame_rho[frame_loaded] = rho;
            frame_theta[frame_loaded] = theta;
            frame_en[frame_loaded] = en;
            frame_loaded++;
        end
        if (!last) return;
        n = frame_loaded;
        nord = 0;
        for (s = 0; s < SLOTS; s++) begin
            live[s] = track_conf[s] > 0;
            taken[s] = 1'b0;
            cnt[s] = track_conf[s] - 1;
        end
        for (j = 0; j < n; j++) begin
            done[j] = !frame_en[j];
            rslot[j] = 0;
            rout[j] = OUT_DISABLED;
        end
        do begin
            found = 1'b0;
            best = 0;
            bj = 0;
            bs = 0;
            for (j = 0; j < n; j++) begin
                if (done[j]) continue;
                for (s = 0; s < SLOTS; s++) begin
                    if (!live[s] || taken[s]) continue;
                    d = 32 * abs_diff(frame_rho[j], track_rho[s]) +
                        25 * abs_diff(frame_theta[j], track_theta[s]);
                    if (!found || d < best) begin
                        found = 1'b1;
                        best = d;
                        bj = j;
                        bs = s;
                    end
                end
            end
            if (found) begin
                done[bj] = 1'b1;
                taken[bs] = 1'b1;
                if (best <= longint'(match_thr) * 32) begin
                    rout[bj] = OUT_MATCHED;
                    rslot[bj] = bs;
                end else begin
                    rout[bj] = OUT_INSERTED;
                end
                order[nord++] = bj;
            end
        end while (found);
        for (j = 0; j < n; j++) begin
            if (!done[j]) begin
                rout[j] = OUT_INSERTED;
                order[nord++] = j;
            end
        end
        for (j = 0; j < nord; j++) begin
            bj = order[j];
            if (rout[bj] == OUT_MATCHED) begin
                s = rslot[bj];
            end else begin
                s = 0;
                while (s < SLOTS && cnt[s] > 0) s++;
                if (s >= SLOTS) begin
                    rout[bj] = OUT_DROPPED;
                    rslot[bj] = 0;
                    continue;
                end
                rslot[bj] = s;
            end
            track_rho[s] = frame_rho[bj];
            track_theta[s] = frame_theta[bj];
            cnt[s] += 2;
        end
        for (s = 0; s < SLOTS; s++) begin
            c = cnt[s];
            if (c < 0) c = 0;
            if (c > conf_ceiling) c = conf_ceiling;
            track_conf[s] = c;
        end
        for (j = 0; j < n; j++) begin
            r.line_idx = 3'(j);
            r.outcome = rout[j];
            r.slot = (rout[j] == OUT_MATCHED || rout[j] == OUT_INSERTED) ? 6'(rslot[j]) : 6'd0;
            r.count = (rout[j] == OUT_MATCHED || rout[j] == OUT_INSERTED) ?
                      6'(track_conf[rslot[j]]) : 6'd0;
            r.last = (j + 1 == n);
            pending_res = {pending_res, r};
        end
        frame_loaded = 0;
    endtask

    // Offers one line request and holds it until taken; called at a rising edge.
    task automatic send_line(input int rho, input int theta, input bit en, input bit last);
        s_valid <= 1'b1;
        s_line_rho <= 16'(rho);
        s_line_theta <= 15'(theta);
        s_line_enable <= en;
        s_last_line <= last;
        do @(posedge aclk); while (!s_ready);
        track_line(rho, theta, en, last);
    endtask

    task automatic sender_gap();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 7);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Waits until every result is in and the block has settled, with the input idle.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_res.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= CFG_DATA_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_MATCH_THRESHOLD) match_thr = value & 16'hFFFF;
        else if (idx == REG_COUNT_CEILING) conf_ceiling = value & 6'h3F;
    endtask

    function automatic int clamp_theta(input int t);
        return (t > 12868) ? 12868 : ((t < -12868) ? -12868 : t);
    endfunction

    initial begin
        int i, k, p, fl, sel;
        int pool_rho[6];
        int pool_theta[6];
        int rho, theta;
        track_res_t typed_got;

        for (i = 0; i < SLOTS; i++) begin
            track_conf[i] = 0;
            track_rho[i] = 0;
            track_theta[i] = 0;
        end
        frame_loaded = 0;
        match_thr = 1200;
        conf_ceiling = 25;

        dir_tab[0] = '{0, 0, 1, 0, 0, '{default: '0}};
        // Empty track store: both lines take the first free slots.
        dir_tab[1] = '{0, 0, 1, 1, 2, '{{3'd0, 6'd0, OUT_INSERTED, 6'd1, 1'b0},
                                        {3'd1, 6'd1, OUT_INSERTED, 6'd1, 1'b1}}};
        dir_tab[2] = '{0, 0, 1, 0, 0, '{default: '0}};
        // Identical lines again: tie goes to the lowest line and lowest slot.
        dir_tab[3] = '{0, 0, 1, 1, 2, '{{3'd0, 6'd0, OUT_MATCHED, 6'd2, 1'b0},
                                        {3'd1, 6'd1, OUT_MATCHED, 6'd2, 1'b1}}};
        dir_tab[4] = '{100, 3, 0, 1, 1, '{{3'd0, 6'd0, OUT_DISABLED, 6'd0, 1'b1},
                                          '0}};
        dir_tab[5] = '{32767, 12868, 1, 0, 0, '{default: '0}};
        dir_tab[6] = '{-32768, -12868, 1, 1, 0, '{default: '0}};
        // Overflowing frame: the third line is ignored, the last one only closes the frame.
        dir_tab[7] = '{5, 5, 1, 0, 0, '{default: '0}};
        dir_tab[8] = '{6, 6, 1, 0, 0, '{default: '0}};
        dir_tab[9] = '{7, 7, 1, 0, 0, '{default: '0}};
        dir_tab[10] = '{8, 8, 1, 1, 0, '{default: '0}};
        dir_tab[11] = '{-1, -1, 1, 1, 0, '{default: '0}};
        dir_tab[12] = '{21845, -5461, 1, 0, 0, '{default: '0}};
        dir_tab[13] = '{-21846, 5461, 0, 1, 0, '{default: '0}};
        dir_tab[14] = '{10, 2, 1, 0, 0, '{default: '0}};
        dir_tab[15] = '{32760, 12860, 1, 1, 0, '{default: '0}};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < N_DIR; i++) begin
            send_line(dir_tab[i].rho, dir_tab[i].theta, dir_tab[i].en, dir_tab[i].last);
            for (k = 0; k < dir_tab[i].n_typed; k++) begin
                typed_got = pending_res[pending_res.size() - dir_tab[i].n_typed + k];
                if (typed_got !== dir_tab[i].typed[k]) begin
                    errors++;
                    $display("%0t: row %0d expected %h, track model gives %h",
                             $time, i, dir_tab[i].typed[k], typed_got);
                end
            end
            sender_gap();
        end

        for (p = 0; p < 6; p++) begin
            drain();
            case (p)
                0: begin write_reg(REG_MATCH_THRESHOLD, 0); write_reg(REG_COUNT_CEILING, 1); end
                1: begin
                    write_reg(REG_MATCH_THRESHOLD, 65535);
                    write_reg(REG_COUNT_CEILING, 63);
                    // Unused register indexes must be ignored.
                    write_reg(REG_SPARE_A, 16'hFFFF);
                    write_reg(REG_SPARE_B, 0);
                end
                2: begin write_reg(REG_MATCH_THRESHOLD, 1200); write_reg(REG_COUNT_CEILING, 25); end
                3: begin
                    write_reg(REG_MATCH_THRESHOLD, $urandom_range(0, 65535));
                    write_reg(REG_COUNT_CEILING, $urandom_range(1, 63));
                end
                4: begin write_reg(REG_MATCH_THRESHOLD, 300); write_reg(REG_COUNT_CEILING, 63); end
                default: begin
                    write_reg(REG_MATCH_THRESHOLD, $urandom_range(0, 4000));
                    write_reg(REG_COUNT_CEILING, $urandom_range(1, 8));
                end
            endcase
            if (p == 2) hold_reqs++;
            for (k = 0; k < 6; k++) begin
                pool_rho[k] = $urandom_range(0, 65535) - 32768;
                pool_theta[k] = $urandom_range(0, 25736) - 12868;
            end
            i = 0;
            while (i < 16) begin
                fl = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 4) : $urandom_range(1, 2);
                for (k = 0; k < fl; k++) begin
                    if ($urandom_range(0, 4) != 0) begin
                        sel = $urandom_range(0, 5);
                        rho = pool_rho[sel] + $urandom_range(0, 80) - 40;
                        if (rho > 32767) rho = 32767;
                        if (rho < -32768) rho = -32768;
                        theta = clamp_theta(pool_theta[sel] + $urandom_range(0, 40) - 20);
                    end else begin
                        rho = $urandom_range(0, 65535) - 32768;
                        theta = $urandom_range(0, 25736) - 12868;
                    end
                    send_line(rho, theta, $urandom_range(0, 9) != 0, k == fl - 1);
                    i++;
                    sender_gap();
                end
            end
        end

        s_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lltm_pkg.sv
rtl/lltm_slot_mem.sv
rtl/lltm_dist_stage.sv
rtl/lane_line_track_matcher.sv
sim/tb_lane_line_track_matcher.sv
